FILE: sv/spl_pkg.sv
// ----------------------------------------------------------------------------
// spl_pkg
// Shared types and constants of the servo pulse limiter: channel words,
// configuration bundle, per-channel timer state and register map codes.
// ----------------------------------------------------------------------------
package spl_pkg;

	// Pulse timer width in bits; the timer counts timebase ticks.
	localparam int COUNT_BITS = 8;
	// Measured widths must hold a full-scale width of 8 bits and one more count.
	localparam int MEAS_BITS  = ((COUNT_BITS > 8) ? COUNT_BITS : 8) + 1;

	// Configuration port.
	localparam int ADDR_BITS = 5;
	localparam int DATA_BITS = 32;

	localparam logic [2:0] REG_OUTPUT_ENABLE    = 3'd0;
	localparam logic [2:0] REG_MIN_LIMIT_INIT   = 3'd1;
	localparam logic [2:0] REG_MAX_LIMIT_INIT   = 3'd2;
	localparam logic [2:0] REG_FULL_SCALE_WIDTH = 3'd3;
	localparam logic [2:0] REG_SAVE_THRESHOLD   = 3'd4;

	// Reset values of the registers.
	localparam logic [7:0] MIN_LIMIT_RESET   = 8'd125;
	localparam logic [7:0] MAX_LIMIT_RESET   = 8'd250;
	localparam logic [7:0] FULL_SCALE_RESET  = 8'd250;
	localparam logic [7:0] SAVE_THRESH_RESET = 8'd50;
	localparam logic [MEAS_BITS-1:0] MEAS_RESET =
		MEAS_BITS'(FULL_SCALE_RESET) + MEAS_BITS'(1);

	typedef struct packed {
		logic in_one_level;
		logic in_two_level;
	} in_word_t;

	typedef struct packed {
		logic       out_one_level;
		logic       out_two_level;
		logic [7:0] lower_limit;
		logic [7:0] upper_limit;
		logic       limit_changed;
		logic       save_ready;
		logic       source_is_two;
	} out_word_t;

	typedef struct packed {
		logic       output_enable;
		logic [7:0] full_scale_width;
		logic [7:0] save_threshold;
	} cfg_t;

	// A register write that also reloads a learned limit.
	typedef struct packed {
		logic       load_lower;
		logic       load_upper;
		logic [7:0] value;
	} lim_wr_t;

	typedef struct packed {
		logic                  active;
		logic                  running;
		logic [COUNT_BITS-1:0] tick;
		logic [MEAS_BITS-1:0]  measured;
		logic [7:0]            compare;
		logic                  level;
	} chan_state_t;

endpackage

FILE: sv/spl_apb.sv
// ----------------------------------------------------------------------------
// spl_apb
// Configuration register file behind a simple APB-style slave port.
// ----------------------------------------------------------------------------
module spl_apb (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [spl_pkg::ADDR_BITS-1:0] paddr,
	input  logic [spl_pkg::DATA_BITS-1:0] pwdata,
	output logic [spl_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready,
	output spl_pkg::cfg_t                 cfg,
	output spl_pkg::lim_wr_t              lim_wr
);

	logic       enable_q;
	logic [7:0] min_init_q;
	logic [7:0] max_init_q;
	logic [7:0] full_scale_q;
	logic [7:0] threshold_q;
	logic [2:0] reg_index;
	logic       wr_en;

	assign pready    = 1'b1;
	assign reg_index = paddr[4:2];
	assign wr_en     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			min_init_q   <= spl_pkg::MIN_LIMIT_RESET;
			max_init_q   <= spl_pkg::MAX_LIMIT_RESET;
			full_scale_q <= spl_pkg::FULL_SCALE_RESET;
			threshold_q  <= spl_pkg::SAVE_THRESH_RESET;
		end else if (wr_en) begin
			unique case (reg_index)
				spl_pkg::REG_OUTPUT_ENABLE:    enable_q     <= pwdata[0];
				spl_pkg::REG_MIN_LIMIT_INIT:   min_init_q   <= pwdata[7:0];
				spl_pkg::REG_MAX_LIMIT_INIT:   max_init_q   <= pwdata[7:0];
				spl_pkg::REG_FULL_SCALE_WIDTH: full_scale_q <= pwdata[7:0];
				spl_pkg::REG_SAVE_THRESHOLD:   threshold_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			spl_pkg::REG_OUTPUT_ENABLE:    prdata = spl_pkg::DATA_BITS'(enable_q);
			spl_pkg::REG_MIN_LIMIT_INIT:   prdata = spl_pkg::DATA_BITS'(min_init_q);
			spl_pkg::REG_MAX_LIMIT_INIT:   prdata = spl_pkg::DATA_BITS'(max_init_q);
			spl_pkg::REG_FULL_SCALE_WIDTH: prdata = spl_pkg::DATA_BITS'(full_scale_q);
			spl_pkg::REG_SAVE_THRESHOLD:   prdata = spl_pkg::DATA_BITS'(threshold_q);
			default:                       prdata = '0;
		endcase
	end

	// Writing an initial limit also reloads the learned limit in the core.
	assign lim_wr.load_lower = wr_en && (reg_index == spl_pkg::REG_MIN_LIMIT_INIT);
	assign lim_wr.load_upper = wr_en && (reg_index == spl_pkg::REG_MAX_LIMIT_INIT);
	assign lim_wr.value      = pwdata[7:0];

	assign cfg.output_enable    = enable_q;
	assign cfg.full_scale_width = full_scale_q;
	assign cfg.save_threshold   = threshold_q;

endmodule

FILE: sv/spl_chan.sv
// ----------------------------------------------------------------------------
// spl_chan
// Next-state logic of one pulse channel for one tick: timer advance, wrap,
// output match, then rising or falling edge of the sampled input.
// ----------------------------------------------------------------------------
module spl_chan (
	input  spl_pkg::chan_state_t          cur,
	input  logic                          level,
	input  spl_pkg::cfg_t                 cfg,
	input  logic [7:0]                    lower,
	input  logic [7:0]                    upper,
	input  logic                          use_own,
	input  logic [spl_pkg::MEAS_BITS-1:0] other_width,
	output spl_pkg::chan_state_t          nxt,
	output logic                          fall
);

	logic [spl_pkg::MEAS_BITS-1:0] ref_width;

	// Upper limit first, then lower, so inverted limits yield the lower one.
	function automatic logic [7:0] clamp_width(input logic [spl_pkg::MEAS_BITS-1:0] w,
	                                           input logic [7:0] lo,
	                                           input logic [7:0] hi);
		logic [31:0] v;
		v = 32'(w);
		if (v > 32'(hi))
			v = 32'(hi);
		if (v < 32'(lo))
			v = 32'(lo);
		return v[7:0];
	endfunction

	always_comb begin
		nxt  = cur;
		fall = 1'b0;

		if (cur.running) begin
			nxt.tick = cur.tick + 1'b1;
			if (cur.tick == '1) begin
				if (cur.active)
					nxt.measured = spl_pkg::MEAS_BITS'(cfg.full_scale_width);
				nxt.active  = 1'b0;
				nxt.level   = 1'b0;
				nxt.running = 1'b0;
			end else if (32'(nxt.tick) == 32'(cur.compare)) begin
				nxt.level = 1'b0;
			end
		end

		ref_width = use_own ? nxt.measured : other_width;

		if (!nxt.active) begin
			if (level) begin
				nxt.active  = 1'b1;
				nxt.compare = clamp_width(ref_width, lower, upper);
				nxt.tick    = '0;
				nxt.running = 1'b1;
				if (cfg.output_enable)
					nxt.level = 1'b1;
			end
		end else if (!level) begin
			nxt.active   = 1'b0;
			nxt.measured = spl_pkg::MEAS_BITS'(nxt.tick);
			fall         = 1'b1;
		end
	end

endmodule

FILE: sv/spl_core.sv
// ----------------------------------------------------------------------------
// spl_core
// Channel state, learned limits and save tracking, updated once per tick.
// ----------------------------------------------------------------------------
module spl_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  spl_pkg::in_word_t    in_s1,
	input  spl_pkg::cfg_t        cfg,
	input  spl_pkg::lim_wr_t     lim_wr,
	output spl_pkg::out_word_t   result
);

	spl_pkg::chan_state_t one_q, two_q, one_nx, two_nx;
	logic       one_fall, two_fall;
	logic [7:0] lower_q, upper_q, lower_nx, upper_nx;
	logic [7:0] stable_q, stable_nx;
	logic       changed_q, changed_nx;
	logic       seen_two_q, seen_two_nx;
	logic [7:0] learn_w;

	function automatic logic [7:0] sat8(input logic [spl_pkg::MEAS_BITS-1:0] w);
		logic [31:0] v;
		v = 32'(w);
		return (v > 32'd255) ? 8'hFF : v[7:0];
	endfunction

	// Channel one runs first and sees the old state of channel two.
	spl_chan u_chan_one (
		.cur         (one_q),
		.level       (in_s1.in_one_level),
		.cfg         (cfg),
		.lower       (lower_q),
		.upper       (upper_q),
		.use_own     (!seen_two_q),
		.other_width (two_q.measured),
		.nxt         (one_nx),
		.fall        (one_fall)
	);

	// Channel two sees channel one as already updated for this tick.
	spl_chan u_chan_two (
		.cur         (two_q),
		.level       (in_s1.in_two_level),
		.cfg         (cfg),
		.lower       (lower_q),
		.upper       (upper_q),
		.use_own     (seen_two_q),
		.other_width (one_nx.measured),
		.nxt         (two_nx),
		.fall        (two_fall)
	);

	assign learn_w = sat8(two_nx.measured);

	always_comb begin
		lower_nx    = lower_q;
		upper_nx    = upper_q;
		stable_nx   = stable_q;
		changed_nx  = changed_q;
		seen_two_nx = seen_two_q || two_fall;
		if (two_fall && cfg.output_enable) begin
			priority if (learn_w < lower_q) begin
				lower_nx   = learn_w;
				changed_nx = 1'b1;
				stable_nx  = '0;
			end else if (learn_w > upper_q) begin
				upper_nx   = learn_w;
				changed_nx = 1'b1;
				stable_nx  = '0;
			end else if (stable_q < cfg.save_threshold) begin
				stable_nx = stable_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_q      <= '{active: 1'b0, running: 1'b0, tick: '0,
			                measured: spl_pkg::MEAS_RESET, compare: '0, level: 1'b0};
			two_q      <= '{active: 1'b0, running: 1'b0, tick: '0,
			                measured: spl_pkg::MEAS_RESET, compare: '0, level: 1'b0};
			lower_q    <= spl_pkg::MIN_LIMIT_RESET;
			upper_q    <= spl_pkg::MAX_LIMIT_RESET;
			stable_q   <= '0;
			changed_q  <= 1'b0;
			seen_two_q <= 1'b0;
		end else begin
			if (step) begin
				one_q      <= one_nx;
				two_q      <= two_nx;
				stable_q   <= stable_nx;
				changed_q  <= changed_nx;
				seen_two_q <= seen_two_nx;
			end
			if (lim_wr.load_lower)
				lower_q <= lim_wr.value;
			else if (step)
				lower_q <= lower_nx;
			if (lim_wr.load_upper)
				upper_q <= lim_wr.value;
			else if (step)
				upper_q <= upper_nx;
		end
	end

	assign result.out_one_level = one_nx.level;
	assign result.out_two_level = two_nx.level;
	assign result.lower_limit   = lower_nx;
	assign result.upper_limit   = upper_nx;
	assign result.limit_changed = changed_nx;
	assign result.save_ready    = (stable_nx >= cfg.save_threshold);
	assign result.source_is_two = seen_two_nx;

	a_changed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		changed_q |=> changed_q)
		else $error("limit change flag dropped");

	a_seen_two_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		seen_two_q |=> seen_two_q)
		else $error("source select fell back to channel one");

	a_limits_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!step && !lim_wr.load_lower && !lim_wr.load_upper)
		|=> ($stable(lower_q) && $stable(upper_q)))
		else $error("limits moved without a tick or a register write");

endmodule

FILE: sv/servo_pulse_limiter.sv
// ----------------------------------------------------------------------------
// servo_pulse_limiter
// Two-channel RC servo pulse regenerator that clamps pulse widths to limits
// learned from channel two.
// ----------------------------------------------------------------------------
// Usage: every word on the input channel is one timebase tick carrying the
// sampled levels of both pulse inputs. For each accepted word the block
// returns exactly one word on the output channel: both regenerated output
// levels, the current lower and upper limits, the sticky limit-changed flag,
// the save-ready indication and the source select.
// A word is registered on acceptance, the result is computed from it
// combinationally and held in the output register when the stage advances,
// and one word per cycle is accepted back to back while the receiver keeps
// taking words; the per-tick timer, edge and clamp logic sits in a single
// stage between those two registers.
// When the receiver stalls, the finished word waits in the output register
// and one more word can be taken into the input register; after that the
// input channel deasserts ready until the output word is taken.
// Reset clears both channels to idle with stopped timers, loads the limits
// from the initial-limit register defaults and clears the change flag, the
// stable counter and the source select. Configuration goes through the APB
// port; writing an initial limit also reloads the learned limit. Writes are
// to be made while no word is in flight, which the block does not enforce.
// ----------------------------------------------------------------------------
module servo_pulse_limiter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  spl_pkg::in_word_t             in_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output spl_pkg::out_word_t            out_word,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [spl_pkg::ADDR_BITS-1:0] paddr,
	input  logic [spl_pkg::DATA_BITS-1:0] pwdata,
	output logic [spl_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready
);

	spl_pkg::in_word_t  in_s1;
	logic               valid_s1;
	spl_pkg::out_word_t out_word_q;
	logic               out_valid_q;
	spl_pkg::out_word_t result;
	spl_pkg::cfg_t      cfg;
	spl_pkg::lim_wr_t   lim_wr;
	logic               step;
	logic               in_accept;

	// The stage advances whenever it holds a word and the output register is
	// free or being emptied in the same cycle.
	assign step      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || step;
	assign in_accept = in_valid && in_ready;

	spl_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.lim_wr  (lim_wr)
	);

	spl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.in_s1  (in_s1),
		.cfg    (cfg),
		.lim_wr (lim_wr),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept)
				valid_s1 <= 1'b1;
			else if (step)
				valid_s1 <= 1'b0;
			if (step)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (in_accept)
			in_s1 <= in_word;
		if (step)
			out_word_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> valid_s1)
		else $error("accepted word did not reach the input register");

endmodule

FILE: tb/servo_pulse_limiter_tb.sv
// ----------------------------------------------------------------------------
// servo_pulse_limiter_tb
// Self-checking bench for the two-channel servo pulse limiter. Pulse trains
// with random widths and gaps, plus some random noise, go into the input
// channel one tick per word. Every accepted tick is run through a local copy
// of the pulse timers, the clamp and the limit learning, and the expected
// output word is checked against what the block returns.
// ----------------------------------------------------------------------------
module servo_pulse_limiter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Register index that decodes to nothing; writes there must be ignored.
	localparam logic [2:0] REG_UNUSED = 3'd5;

	// The receiver stops once, after this many output words, for this long.
	localparam int HOLD_AT     = 200;
	localparam int HOLD_CYCLES = 150;
	// Cycles without progress while work is outstanding before giving up.
	localparam int STUCK_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_ready;
	spl_pkg::in_word_t  in_word = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	spl_pkg::out_word_t out_word;

	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [spl_pkg::ADDR_BITS-1:0] paddr = '0;
	logic [spl_pkg::DATA_BITS-1:0] pwdata = '0;
	logic [spl_pkg::DATA_BITS-1:0] prdata;
	logic                          pready;

	// Ticks waiting to be offered, and output words the block still owes us.
	spl_pkg::in_word_t  ticks_to_send[$];
	spl_pkg::out_word_t words_due[$];

	// When set, neither side inserts random idle cycles.
	logic calm = 1'b0;

	int fail_count = 0;
	int words_seen = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	int stuck_cycles = 0;

	// Local copy of the configuration.
	logic       cfg_enable = 1'b0;
	logic [7:0] cfg_full_scale = spl_pkg::FULL_SCALE_RESET;
	logic [7:0] cfg_threshold = spl_pkg::SAVE_THRESH_RESET;

	// Local copy of the per-channel pulse state and of the learned limits.
	logic                           ch_active [2] = '{1'b0, 1'b0};
	logic                           ch_running [2] = '{1'b0, 1'b0};
	logic [spl_pkg::COUNT_BITS-1:0] ch_count [2] = '{'0, '0};
	logic [spl_pkg::MEAS_BITS-1:0]  ch_width [2] =
		'{spl_pkg::MEAS_RESET, spl_pkg::MEAS_RESET};
	logic [7:0]                     ch_target [2] = '{8'd0, 8'd0};
	logic                           ch_level [2] = '{1'b0, 1'b0};
	logic [7:0]                     lim_lower = spl_pkg::MIN_LIMIT_RESET;
	logic [7:0]                     lim_upper = spl_pkg::MAX_LIMIT_RESET;
	logic [7:0]                     stable_ticks = 8'd0;
	logic                           widened = 1'b0;
	logic                           two_seen = 1'b0;

	servo_pulse_limiter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #6 clk = ~clk;

	// Clamp a captured width to the limits. The upper limit is applied first,
	// so with inverted limits the lower one wins.
	function automatic logic [7:0] clamp_width(input logic [spl_pkg::MEAS_BITS-1:0] w);
		int v;
		v = int'(w);
		if (v > int'(lim_upper))
			v = int'(lim_upper);
		if (v < int'(lim_lower))
			v = int'(lim_lower);
		return 8'(v);
	endfunction

	// A channel two width outside the limits widens them and restarts the
	// stable count; a width inside counts as stable up to the threshold.
	function automatic void learn_width(input logic [spl_pkg::MEAS_BITS-1:0] w);
		logic [7:0] s;
		s = (int'(w) > 255) ? 8'd255 : 8'(w);
		if (s < lim_lower) begin
			lim_lower = s;
			widened = 1'b1;
			stable_ticks = 8'd0;
		end else if (s > lim_upper) begin
			lim_upper = s;
			widened = 1'b1;
			stable_ticks = 8'd0;
		end else if (stable_ticks < cfg_threshold) begin
			stable_ticks = stable_ticks + 8'd1;
		end
	endfunction

	// Advance the predicted block by one timebase tick and return the output
	// word that tick produces. Channel one is handled before channel two.
	function automatic spl_pkg::out_word_t regenerate_tick(input spl_pkg::in_word_t w);
		logic               lv [2];
		int                 ch;
		spl_pkg::out_word_t r;
		lv[0] = w.in_one_level;
		lv[1] = w.in_two_level;
		for (ch = 0; ch < 2; ch++) begin
			// The running timer moves first. A wrap ends everything, and a
			// pulse still high at the wrap is recorded as full scale.
			if (ch_running[ch]) begin
				ch_count[ch] = ch_count[ch] + 1'b1;
				if (ch_count[ch] == '0) begin
					if (ch_active[ch])
						ch_width[ch] = spl_pkg::MEAS_BITS'(cfg_full_scale);
					ch_active[ch] = 1'b0;
					ch_level[ch] = 1'b0;
					ch_running[ch] = 1'b0;
				end else if (32'(ch_count[ch]) == 32'(ch_target[ch])) begin
					ch_level[ch] = 1'b0;
				end
			end
			// Then the input level: rising edge restarts the timer and the
			// output pulse, falling edge captures the width.
			if (!ch_active[ch]) begin
				if (lv[ch]) begin
					ch_active[ch] = 1'b1;
					ch_target[ch] = clamp_width(ch_width[two_seen ? 1 : 0]);
					ch_count[ch] = '0;
					ch_running[ch] = 1'b1;
					if (cfg_enable)
						ch_level[ch] = 1'b1;
				end
			end else if (!lv[ch]) begin
				ch_active[ch] = 1'b0;
				ch_width[ch] = spl_pkg::MEAS_BITS'(ch_count[ch]);
				if (ch == 1) begin
					two_seen = 1'b1;
					if (cfg_enable)
						learn_width(ch_width[1]);
				end
			end
		end
		r.out_one_level = ch_level[0];
		r.out_two_level = ch_level[1];
		r.lower_limit = lim_lower;
		r.upper_limit = lim_upper;
		r.limit_changed = widened;
		r.save_ready = (stable_ticks >= cfg_threshold);
		r.source_is_two = two_seen;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
				$time, name, want, got);
		end
	endtask

	// Driver: offers the queued ticks one word at a time. An offered word
	// stays put until taken; the prediction is made at the accepting edge so
	// that it sees exactly the ticks the block sees, in the same order.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				words_due.push_back(regenerate_tick(in_word));
			if (in_valid && !in_ready) begin
				// Keep offering the same word.
			end else if (ticks_to_send.size() != 0 &&
					(calm || $urandom_range(99) >= 10)) begin
				in_valid <= 1'b1;
				in_word <= ticks_to_send.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: takes output words, compares them field by field against the
	// oldest word due, and drives ready. Once in the run it holds ready low
	// for a long stretch so the block fills and pushes back on its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				words_seen++;
				if (words_due.size() == 0) begin
					fail_count++;
					$display("%0t ns: output word with none due, actual %p",
						$time, out_word);
				end else begin
					spl_pkg::out_word_t want;
					want = words_due.pop_front();
					check_field("out_one_level", 8'(want.out_one_level),
						8'(out_word.out_one_level));
					check_field("out_two_level", 8'(want.out_two_level),
						8'(out_word.out_two_level));
					check_field("lower_limit", want.lower_limit, out_word.lower_limit);
					check_field("upper_limit", want.upper_limit, out_word.upper_limit);
					check_field("limit_changed", 8'(want.limit_changed),
						8'(out_word.limit_changed));
					check_field("save_ready", 8'(want.save_ready),
						8'(out_word.save_ready));
					check_field("source_is_two", 8'(want.source_is_two),
						8'(out_word.source_is_two));
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (!hold_done && words_seen == HOLD_AT) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || $urandom_range(99) >= 10;
			end
		end
	end

	// Watchdog: counts cycles in which work is outstanding but no word moves.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(!in_valid && words_due.size() == 0)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// One register write: setup cycle, then access cycle. The predictor takes
	// the new value at once, which is safe since writes happen only when idle.
	task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= spl_pkg::DATA_BITS'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			spl_pkg::REG_OUTPUT_ENABLE:    cfg_enable = value[0];
			spl_pkg::REG_MIN_LIMIT_INIT:   lim_lower = value;
			spl_pkg::REG_MAX_LIMIT_INIT:   lim_upper = value;
			spl_pkg::REG_FULL_SCALE_WIDTH: cfg_full_scale = value;
			spl_pkg::REG_SAVE_THRESHOLD:   cfg_threshold = value;
			default: ;
		endcase
	endtask

	task automatic write_all(input logic enable, input logic [7:0] lower,
			input logic [7:0] upper, input logic [7:0] full,
			input logic [7:0] thresh);
		write_reg(spl_pkg::REG_OUTPUT_ENABLE, {7'd0, enable});
		write_reg(spl_pkg::REG_MIN_LIMIT_INIT, lower);
		write_reg(spl_pkg::REG_MAX_LIMIT_INIT, upper);
		write_reg(spl_pkg::REG_FULL_SCALE_WIDTH, full);
		write_reg(spl_pkg::REG_SAVE_THRESHOLD, thresh);
	endtask

	// Queue ticks carrying independent pulse trains on both inputs. Widths and
	// gaps are random up to the given bounds; a share of them is long enough
	// to let the timer wrap, and a share of ticks is replaced by random levels.
	task automatic queue_pulses(input int count, input int wmax, input int gmax,
			input int noise_pct, input int long_pct);
		logic              lvl [2];
		int                remain [2];
		int                n;
		int                ch;
		spl_pkg::in_word_t w;
		lvl[0] = 1'b0;
		lvl[1] = 1'b0;
		remain[0] = $urandom_range(gmax, 1);
		remain[1] = $urandom_range(gmax, 1);
		for (n = 0; n < count; n++) begin
			for (ch = 0; ch < 2; ch++) begin
				remain[ch]--;
				if (remain[ch] <= 0) begin
					lvl[ch] = !lvl[ch];
					if ($urandom_range(99) < long_pct)
						remain[ch] = $urandom_range(300, 250);
					else if (lvl[ch])
						remain[ch] = $urandom_range(wmax, 1);
					else
						remain[ch] = $urandom_range(gmax, 1);
				end
			end
			w.in_one_level = lvl[0];
			w.in_two_level = lvl[1];
			if ($urandom_range(99) < noise_pct)
				w = spl_pkg::in_word_t'(2'($urandom_range(3, 0)));
			ticks_to_send.push_back(w);
		end
	endtask

	// Sender pause: wait until everything queued has gone in and every word
	// due has come out, then let the pipeline settle. Checked on the falling
	// edge so the driver's updates at the rising edge are already visible.
	task automatic drain;
		do
			@(negedge clk);
		while (ticks_to_send.size() != 0 || in_valid || words_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_phase(input logic enable, input logic [7:0] lower,
			input logic [7:0] upper, input logic [7:0] full,
			input logic [7:0] thresh, input int count, input int wmax,
			input int gmax, input int noise_pct, input int long_pct,
			input logic quiet);
		write_all(enable, lower, upper, full, thresh);
		@(negedge clk);
		calm = quiet;
		queue_pulses(count, wmax, gmax, noise_pct, long_pct);
		drain();
	endtask

	// Directed ticks as {one, two} levels: single-tick pulses on both inputs, the
	// channel two one below the lower limit, a channel one pulse, a channel two
	// pulse above the upper limit, then in-range pulses that count toward the save threshold.
	logic [1:0] directed [24] = '{
		2'b11, 2'b00,
		2'b10, 2'b10, 2'b10, 2'b00,
		2'b01, 2'b01, 2'b01, 2'b01, 2'b01, 2'b01, 2'b01, 2'b01, 2'b00,
		2'b11, 2'b11, 2'b11, 2'b00, 2'b00,
		2'b01, 2'b01, 2'b00, 2'b11
	};

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: narrow limits, full scale at its top, low threshold.
		// A write to an unmapped address must change nothing.
		write_all(1'b1, 8'd2, 8'd6, 8'd255, 8'd3);
		write_reg(REG_UNUSED, 8'hA5);
		@(negedge clk);
		foreach (directed[i])
			ticks_to_send.push_back(spl_pkg::in_word_t'(directed[i]));
		drain();

		// Mid-range limits with a little noise; the long receiver hold-off
		// lands in this phase.
		run_phase(1'b1, 8'd10, 8'd40, 8'd250, 8'd10, 350, 60, 60, 5, 0, 1'b0);
		// All limits at zero and a zero full scale: zero compare widths keep
		// the output high until the timer wraps.
		run_phase(1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 450, 8, 8, 0, 15, 1'b0);
		// Everything at its top value; learning can only lower the floor.
		run_phase(1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 250, 40, 40, 0, 5, 1'b0);
		// Limits start inverted, so clamps land on the lower limit until learning moves them.
		run_phase(1'b1, 8'd30, 8'd10, 8'd128, 8'd5, 250, 50, 30, 0, 3, 1'b0);
		// Outputs and learning disabled, heavy noise.
		run_phase(1'b0, 8'd5, 8'd50, 8'd100, 8'd1, 150, 20, 20, 30, 5, 1'b0);
		// A long stretch with no idling on either side.
		run_phase(1'b1, 8'd8, 8'd24, 8'd17, 8'd2, 350, 30, 20, 2, 2, 1'b1);

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: servo_pulse_limiter.f
sv/spl_pkg.sv
sv/spl_apb.sv
sv/spl_chan.sv
sv/spl_core.sv
sv/servo_pulse_limiter.sv
tb/servo_pulse_limiter_tb.sv
